// ----- src/icna_pkg.sv -----
`default_nettype none
package icna_pkg;

  localparam int MAX_DIM      = 256;
  localparam int MAX_CHANNELS = 4;

  // configuration register map, register i at byte address 4*i
  typedef enum logic [2:0] {
    REG_IMAGE_HEIGHT   = 3'd0,
    REG_IMAGE_WIDTH    = 3'd1,
    REG_CHANNEL_COUNT  = 3'd2,
    REG_CROP_SIDE      = 3'd3,
    REG_WIN_SIDE       = 3'd4,
    REG_SCALE_FACTOR   = 3'd5,
    REG_AUGMENT_ENABLE = 3'd6,
    REG_TRAINING_MODE  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] MIRROR_COLS = 2'd1;
  localparam logic [1:0] MIRROR_ROWS = 2'd2;

  localparam logic [1:0] ROTATE_POS90 = 2'd1;
  localparam logic [1:0] ROTATE_NEG90 = 2'd2;
  localparam logic [1:0] ROTATE_180   = 2'd3;

  typedef struct packed {
    logic [8:0]  image_height;
    logic [8:0]  image_width;
    logic [2:0]  channel_count;
    logic [8:0]  crop_side;
    logic [8:0]  win_side;
    logic [23:0] scale_factor;
    logic [1:0]  augment_enable;
    logic        training_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  batch_item;
    logic [1:0]  channel;
    logic [7:0]  src_row;
    logic [7:0]  src_col;
    logic [7:0]  pixel;
    logic [15:0] mean_value;
    logic [7:0]  row_offset_draw;
    logic [7:0]  col_offset_draw;
    logic [1:0]  mirror_choice;
    logic [1:0]  rotate_choice;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_batch_item;
    logic [1:0]         out_channel;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic signed [31:0] out_value;
    logic               config_error;
  } out_item_t;

  // coordinate path result
  typedef struct packed {
    logic       keep;
    logic       err;
    logic [7:0] row;
    logic [7:0] col;
  } remap_t;

  function automatic logic [8:0] clamp_dim(input logic [8:0] v);
    clamp_dim = (v > 9'(MAX_DIM)) ? 9'(MAX_DIM) : v;
  endfunction

endpackage
`default_nettype wire

// ----- src/icna_remap.sv -----
`default_nettype none
module icna_remap (
  input  var icna_pkg::cfg_t     cfg,
  input  var icna_pkg::in_item_t item,
  output icna_pkg::remap_t       res
);

  logic [8:0] ih, iw, cs, ws, oh, ow, hoff, woff;
  logic [2:0] nch;
  logic       crop_on, win_on;
  logic signed [9:0] r_s, c_s;
  logic [8:0] r_win, c_win, r_mir, c_mir, r_rot, c_rot;
  logic       chan_ok, in_img, in_win;

  always_comb begin
    ih = icna_pkg::clamp_dim(cfg.image_height);
    iw = icna_pkg::clamp_dim(cfg.image_width);
    cs = icna_pkg::clamp_dim(cfg.crop_side);
    ws = icna_pkg::clamp_dim(cfg.win_side);
    nch = (cfg.channel_count > 3'(icna_pkg::MAX_CHANNELS)) ?
          3'(icna_pkg::MAX_CHANNELS) : cfg.channel_count;
    crop_on = (cs != 9'd0);
    win_on  = (ws != 9'd0);

    if (crop_on) begin
      oh = cs;
      ow = cs;
    end else if (win_on) begin
      oh = ws;
      ow = ws;
    end else begin
      oh = ih;
      ow = iw;
    end

    // drawn offsets only when training with a crop, else centred
    if (cfg.training_mode && crop_on) begin
      hoff = {1'b0, item.row_offset_draw};
      woff = {1'b0, item.col_offset_draw};
    end else begin
      hoff = (ih >= oh) ? ((ih - oh) >> 1) : 9'd0;
      woff = (iw >= ow) ? ((iw - ow) >> 1) : 9'd0;
    end

    chan_ok = ({1'b0, item.channel} < nch);
    in_img  = ({1'b0, item.src_row} < ih) && ({1'b0, item.src_col} < iw);

    r_s = $signed({2'b00, item.src_row}) - $signed({1'b0, hoff});
    c_s = $signed({2'b00, item.src_col}) - $signed({1'b0, woff});
    in_win = !r_s[9] && !c_s[9] && (r_s[8:0] < oh) && (c_s[8:0] < ow);
    r_win = r_s[8:0];
    c_win = c_s[8:0];

    r_mir = r_win;
    c_mir = c_win;
    if (cfg.augment_enable[0]) begin
      case (item.mirror_choice)
        icna_pkg::MIRROR_COLS: c_mir = ow - 9'd1 - c_win;
        icna_pkg::MIRROR_ROWS: r_mir = oh - 9'd1 - r_win;
        default: ;
      endcase
    end

    r_rot = r_mir;
    c_rot = c_mir;
    if (cfg.augment_enable[1]) begin
      case (item.rotate_choice)
        icna_pkg::ROTATE_POS90: begin
          r_rot = ow - 9'd1 - c_mir;
          c_rot = r_mir;
        end
        icna_pkg::ROTATE_NEG90: begin
          r_rot = c_mir;
          c_rot = oh - 9'd1 - r_mir;
        end
        icna_pkg::ROTATE_180: begin
          r_rot = oh - 9'd1 - r_mir;
          c_rot = ow - 9'd1 - c_mir;
        end
        default: ;
      endcase
    end

    res.err  = crop_on && win_on;
    res.keep = chan_ok && in_img && in_win;
    res.row  = r_rot[7:0];
    res.col  = c_rot[7:0];
  end

endmodule
`default_nettype wire

// ----- src/icna_scale.sv -----
`default_nettype none
module icna_scale (
  input  var logic [7:0]         pixel,
  input  var logic [15:0]        mean_value,
  input  var logic [23:0]        scale_factor,
  output logic signed [31:0]     value
);

  logic signed [16:0] diff;
  logic signed [41:0] prod;
  logic signed [41:0] rnd;

  always_comb begin
    // q8.8 difference times q8.16 scale gives q16.24
    diff = $signed({1'b0, pixel, 8'h00}) - $signed({1'b0, mean_value});
    prod = 42'(diff) * 42'($signed({1'b0, scale_factor}));
    // round half up, then drop eight fraction bits
    rnd  = prod + 42'sd128;
    if ((rnd[41:39] == 3'b000) || (rnd[41:39] == 3'b111)) begin
      value = rnd[39:8];
    end else if (rnd[41]) begin
      value = 32'sh8000_0000;
    end else begin
      value = 32'sh7fff_ffff;
    end
  end

endmodule
`default_nettype wire

// ----- src/image_crop_normalize_augment_top.sv -----
// image crop / mirror / rotate / mean-subtract block
// input channel (in_valid, in_ready, in_data): one source byte sample per item,
//   with its coordinates, channel, per-pixel mean and the per-image draws
// result channel (out_valid, out_ready, out_data): zero or one result per item,
//   the normalised q16.16 value at its destination row and column
// configuration: apb-style port, register i at byte address 4*i, write only
//   while no item is in flight; pready is tied high, reads return the register
// datapath: an accepted item is taken into the input register, which feeds the
//   result register through the combinational path
// throughput: one item per cycle while out_ready is high; the path is one
//   17x25 multiply plus rounding and saturation, coordinate compare and remap
// items off the window, image or channel count give no result; when crop and
//   window are both set every item yields a result flagged config_error
// reset (rst_n low, synchronous): pipeline emptied, registers return to
//   256x256 image, 3 channels, no crop or window, scale 1.0, no augmentation
// stall: while out_ready is low the result holds; one more item is taken
//   into the input register, then in_ready drops until the result moves
`default_nettype none
module image_crop_normalize_augment_top (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                in_valid,
  output logic                    in_ready,
  input  var icna_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  var logic                out_ready,
  output icna_pkg::out_item_t     out_data,
  input  var logic                cfg_psel,
  input  var logic                cfg_penable,
  input  var logic                cfg_pwrite,
  input  var logic [4:0]          cfg_paddr,
  input  var logic [31:0]         cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  // configuration registers
  icna_pkg::cfg_t     cfg_r;
  icna_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  // input register and result register
  logic                s1_v_r, s1_v_nxt;
  icna_pkg::in_item_t  s1_item_r;
  logic                out_v_r, out_v_nxt;
  icna_pkg::out_item_t out_item_r, out_item_nxt;

  icna_pkg::remap_t    remap;
  logic signed [31:0]  value;
  logic                adv;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = icna_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_height   <= 9'd256;
      cfg_r.image_width    <= 9'd256;
      cfg_r.channel_count  <= 3'd3;
      cfg_r.crop_side      <= 9'd0;
      cfg_r.win_side       <= 9'd0;
      cfg_r.scale_factor   <= 24'd65536;
      cfg_r.augment_enable <= 2'd0;
      cfg_r.training_mode  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        icna_pkg::REG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_pwdata[8:0];
        icna_pkg::REG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_pwdata[8:0];
        icna_pkg::REG_CHANNEL_COUNT:  cfg_r.channel_count  <= cfg_pwdata[2:0];
        icna_pkg::REG_CROP_SIDE:      cfg_r.crop_side      <= cfg_pwdata[8:0];
        icna_pkg::REG_WIN_SIDE:       cfg_r.win_side       <= cfg_pwdata[8:0];
        icna_pkg::REG_SCALE_FACTOR:   cfg_r.scale_factor   <= cfg_pwdata[23:0];
        icna_pkg::REG_AUGMENT_ENABLE: cfg_r.augment_enable <= cfg_pwdata[1:0];
        icna_pkg::REG_TRAINING_MODE:  cfg_r.training_mode  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      icna_pkg::REG_IMAGE_HEIGHT:   cfg_prdata = {23'd0, cfg_r.image_height};
      icna_pkg::REG_IMAGE_WIDTH:    cfg_prdata = {23'd0, cfg_r.image_width};
      icna_pkg::REG_CHANNEL_COUNT:  cfg_prdata = {29'd0, cfg_r.channel_count};
      icna_pkg::REG_CROP_SIDE:      cfg_prdata = {23'd0, cfg_r.crop_side};
      icna_pkg::REG_WIN_SIDE:       cfg_prdata = {23'd0, cfg_r.win_side};
      icna_pkg::REG_SCALE_FACTOR:   cfg_prdata = {8'd0, cfg_r.scale_factor};
      icna_pkg::REG_AUGMENT_ENABLE: cfg_prdata = {30'd0, cfg_r.augment_enable};
      icna_pkg::REG_TRAINING_MODE:  cfg_prdata = {31'd0, cfg_r.training_mode};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  // result register free or being emptied this cycle
  assign adv      = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || adv;

  icna_remap u_remap (
    .cfg  (cfg_r),
    .item (s1_item_r),
    .res  (remap)
  );

  icna_scale u_scale (
    .pixel        (s1_item_r.pixel),
    .mean_value   (s1_item_r.mean_value),
    .scale_factor (cfg_r.scale_factor),
    .value        (value)
  );

  // result assembly, the error case zeroes every other field
  always_comb begin
    if (remap.err) begin
      out_item_nxt = '0;
      out_item_nxt.config_error = 1'b1;
    end else begin
      out_item_nxt.out_batch_item = s1_item_r.batch_item;
      out_item_nxt.out_channel    = s1_item_r.channel;
      out_item_nxt.out_row        = remap.row;
      out_item_nxt.out_col        = remap.col;
      out_item_nxt.out_value      = value;
      out_item_nxt.config_error   = 1'b0;
    end
  end

  always_comb begin
    s1_v_nxt  = in_ready ? in_valid : s1_v_r;
    out_v_nxt = adv ? (s1_v_r && (remap.keep || remap.err)) : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (adv && s1_v_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ----- src/icna_checker.sv -----
`default_nettype none
module icna_checker (
  input var logic                clk,
  input var logic                rst_n,
  input var logic                in_valid,
  input var logic                in_ready,
  input var logic                out_valid,
  input var logic                out_ready,
  input var icna_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an empty result side never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // error results carry nothing else
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.config_error |->
      out_data.out_batch_item == 8'd0 && out_data.out_channel == 2'd0 &&
      out_data.out_row == 8'd0 && out_data.out_col == 8'd0 &&
      out_data.out_value == 32'sd0)
    else $error("error result with non-zero fields");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // a new result needs an item taken earlier into the input register
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1))
    else $error("result without an accepted item");

endmodule

bind image_crop_normalize_augment_top icna_checker u_icna_checker (.*);
`default_nettype wire

// ----- test/image_crop_normalize_augment_top_test.sv -----
`timescale 1ns / 100ps
module image_crop_normalize_augment_top_test;

  // saturation bounds of the signed q16.16 result
  localparam longint VALUE_MAX = 64'sd2147483647;
  localparam longint VALUE_MIN = -64'sd2147483648;
  // cycles with no item, result or register write before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // cycles let pass after the last result, enough for a dropped item to clear
  localparam int SETTLE_CYCLES = 4;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  icna_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  icna_pkg::out_item_t out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [4:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // shadow of the register file, kept in step with every write
  icna_pkg::cfg_t      shadow;
  // results still owed by the block, oldest first
  icna_pkg::out_item_t predicted_samples[$];
  icna_pkg::out_item_t oldest;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  // idling odds in percent, changed from phase to phase
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;

  image_crop_normalize_augment_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register values above the largest image side act as the largest side
  function automatic int dim_clamp(input int v);
    return (v > icna_pkg::MAX_DIM) ? icna_pkg::MAX_DIM : v;
  endfunction

  // output size and window origin for the current settings and this item's draws;
  // returns 1 when crop and window are both set
  function automatic bit window_geometry(input logic [7:0] rdraw, input logic [7:0] cdraw,
                                         output int oh, output int ow, output int hoff,
                                         output int woff, output int ih, output int iw);
    int cs, ws;
    ih = dim_clamp(int'(shadow.image_height));
    iw = dim_clamp(int'(shadow.image_width));
    cs = dim_clamp(int'(shadow.crop_side));
    ws = dim_clamp(int'(shadow.win_side));
    if (cs != 0) begin
      oh = cs;
      ow = cs;
    end else if (ws != 0) begin
      oh = ws;
      ow = ws;
    end else begin
      oh = ih;
      ow = iw;
    end
    // drawn offsets only in training with a crop, else the window is centred
    if (shadow.training_mode && cs != 0) begin
      hoff = int'(rdraw);
      woff = int'(cdraw);
    end else begin
      hoff = (ih >= oh) ? (ih - oh) / 2 : 0;
      woff = (iw >= ow) ? (iw - ow) / 2 : 0;
    end
    return (cs != 0 && ws != 0);
  endfunction

  // expected result of one source sample; returns 0 when the sample is dropped
  function automatic bit predict_sample(input icna_pkg::in_item_t px,
                                        output icna_pkg::out_item_t res);
    int     ih, iw, oh, ow, hoff, woff, nch, r, c, t;
    longint diff, prod, q;
    res = '0;
    if (window_geometry(px.row_offset_draw, px.col_offset_draw, oh, ow, hoff, woff, ih, iw))
    begin
      res.config_error = 1'b1;
      return 1'b1;
    end
    nch = (shadow.channel_count > icna_pkg::MAX_CHANNELS) ? icna_pkg::MAX_CHANNELS
                                                          : int'(shadow.channel_count);
    if (int'(px.channel) >= nch || int'(px.src_row) >= ih || int'(px.src_col) >= iw)
      return 1'b0;
    r = int'(px.src_row) - hoff;
    c = int'(px.src_col) - woff;
    if (r < 0 || c < 0 || r >= oh || c >= ow)
      return 1'b0;
    if (shadow.augment_enable[0]) begin
      if (px.mirror_choice == icna_pkg::MIRROR_COLS) c = ow - 1 - c;
      else if (px.mirror_choice == icna_pkg::MIRROR_ROWS) r = oh - 1 - r;
    end
    if (shadow.augment_enable[1]) begin
      case (px.rotate_choice)
        icna_pkg::ROTATE_POS90: begin
          t = r;
          r = ow - 1 - c;
          c = t;
        end
        icna_pkg::ROTATE_NEG90: begin
          t = r;
          r = c;
          c = oh - 1 - t;
        end
        icna_pkg::ROTATE_180: begin
          r = oh - 1 - r;
          c = ow - 1 - c;
        end
        default: ;
      endcase
    end
    // q8.8 difference times q8.16 scale, rounded half up to q16.16
    diff = longint'(px.pixel) * 256 - longint'(px.mean_value);
    prod = diff * longint'(shadow.scale_factor) + 128;
    q = prod >>> 8;
    if (q > VALUE_MAX) q = VALUE_MAX;
    if (q < VALUE_MIN) q = VALUE_MIN;
    res.out_batch_item = px.batch_item;
    res.out_channel    = px.channel;
    res.out_row        = r[7:0];
    res.out_col        = c[7:0];
    res.out_value      = q[31:0];
    return 1'b1;
  endfunction

  function automatic icna_pkg::in_item_t make_sample(input int batch, input int chan,
                                                     input int row, input int col,
                                                     input int pix, input int mean,
                                                     input int rdraw, input int cdraw,
                                                     input int mir, input int rot);
    icna_pkg::in_item_t px;
    px.batch_item      = batch[7:0];
    px.channel         = chan[1:0];
    px.src_row         = row[7:0];
    px.src_col         = col[7:0];
    px.pixel           = pix[7:0];
    px.mean_value      = mean[15:0];
    px.row_offset_draw = rdraw[7:0];
    px.col_offset_draw = cdraw[7:0];
    px.mirror_choice   = mir[1:0];
    px.rotate_choice   = rot[1:0];
    return px;
  endfunction

  // stop feeding, let every owed result arrive, then let the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb write: setup, access, then the bus returns to idle
  task automatic write_reg(input icna_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // written at this edge
    case (idx)
      icna_pkg::REG_IMAGE_HEIGHT:   shadow.image_height   = val[8:0];
      icna_pkg::REG_IMAGE_WIDTH:    shadow.image_width    = val[8:0];
      icna_pkg::REG_CHANNEL_COUNT:  shadow.channel_count  = val[2:0];
      icna_pkg::REG_CROP_SIDE:      shadow.crop_side      = val[8:0];
      icna_pkg::REG_WIN_SIDE:       shadow.win_side       = val[8:0];
      icna_pkg::REG_SCALE_FACTOR:   shadow.scale_factor   = val[23:0];
      icna_pkg::REG_AUGMENT_ENABLE: shadow.augment_enable = val[1:0];
      icna_pkg::REG_TRAINING_MODE:  shadow.training_mode  = val[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int h, input int w, input int ch, input int crop,
                           input int win, input int scale, input int aug, input int train);
    wait_idle();
    write_reg(icna_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(icna_pkg::REG_IMAGE_WIDTH, w);
    write_reg(icna_pkg::REG_CHANNEL_COUNT, ch);
    write_reg(icna_pkg::REG_CROP_SIDE, crop);
    write_reg(icna_pkg::REG_WIN_SIDE, win);
    write_reg(icna_pkg::REG_SCALE_FACTOR, scale);
    write_reg(icna_pkg::REG_AUGMENT_ENABLE, aug);
    write_reg(icna_pkg::REG_TRAINING_MODE, train);
  endtask

  // present one item, hold it until taken, then record what it should give
  task automatic send_sample(input icna_pkg::in_item_t px, output bit kept);
    icna_pkg::out_item_t res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    kept = predict_sample(px, res);
    if (kept) predicted_samples.push_back(res);
  endtask

  task automatic send_list(input icna_pkg::in_item_t list[$]);
    bit kept;
    foreach (list[i]) send_sample(list[i], kept);
  endtask

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // receiver: random back-pressure, every result taken is checked against the oldest owed
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (predicted_samples.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        oldest = predicted_samples.pop_front();
        check_field("out_batch_item", 32'(oldest.out_batch_item),
                    32'(out_data.out_batch_item));
        check_field("out_channel", 32'(oldest.out_channel), 32'(out_data.out_channel));
        check_field("out_row", 32'(oldest.out_row), 32'(out_data.out_row));
        check_field("out_col", 32'(oldest.out_col), 32'(out_data.out_col));
        check_field("out_value", oldest.out_value, out_data.out_value);
        check_field("config_error", 32'(oldest.config_error), 32'(out_data.config_error));
      end
    end
  end

  // watchdog: any item, result or register access counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // settings straight after reset: full 256x256 image, three channels, unit scale
  task automatic test_reset_values();
    icna_pkg::in_item_t list[$];
    list.push_back(make_sample(255, 2, 0, 0, 255, 0, 0, 0, 0, 0));
    list.push_back(make_sample(0, 0, 255, 255, 0, 65535, 255, 255, 3, 3));
    // channel beyond the channel count is dropped
    list.push_back(make_sample(7, 3, 12, 40, 200, 100, 0, 0, 0, 0));
    list.push_back(make_sample(1, 1, 128, 64, 128, 32768, 0, 0, 1, 2));
    send_list(list);
  endtask

  // crop and window together flag every item as an error
  task automatic test_crop_window_clash();
    icna_pkg::in_item_t list[$];
    configure(64, 64, 4, 8, 16, 65536, 3, 1);
    list.push_back(make_sample(9, 1, 30, 30, 77, 1234, 10, 20, 1, 1));
    list.push_back(make_sample(200, 3, 255, 0, 0, 0, 0, 0, 0, 0));
    send_list(list);
  endtask

  // training crop at drawn offsets with every mirror and rotation
  task automatic test_training_crop_augment();
    icna_pkg::in_item_t list[$];
    configure(64, 64, 4, 8, 0, 65536, 3, 1);
    list.push_back(make_sample(2, 0, 10, 20, 10, 500, 10, 20, 1, 0));
    list.push_back(make_sample(2, 1, 11, 22, 20, 600, 10, 20, 2, 0));
    // mirror choice three means no mirroring
    list.push_back(make_sample(2, 2, 12, 23, 30, 700, 10, 20, 3, 0));
    list.push_back(make_sample(2, 3, 13, 24, 40, 800, 10, 20, 0, 1));
    list.push_back(make_sample(3, 0, 17, 27, 50, 900, 10, 20, 0, 2));
    list.push_back(make_sample(3, 1, 14, 21, 60, 1000, 10, 20, 0, 3));
    list.push_back(make_sample(3, 2, 15, 26, 70, 1100, 10, 20, 1, 3));
    // drawn offsets reaching past the image edge
    list.push_back(make_sample(4, 0, 62, 63, 90, 0, 60, 60, 2, 1));
    send_list(list);
  endtask

  // centred window larger than the image, offset taken as zero
  task automatic test_window_exceeds_image();
    icna_pkg::in_item_t list[$];
    configure(10, 20, 2, 0, 32, 65536, 0, 0);
    list.push_back(make_sample(5, 1, 9, 19, 100, 25600, 0, 0, 0, 0));
    list.push_back(make_sample(5, 0, 10, 5, 100, 0, 0, 0, 0, 0));
    send_list(list);
  endtask

  // registers above the limits, and the scale extremes driving saturation
  task automatic test_oversized_registers();
    icna_pkg::in_item_t list[$];
    configure(511, 300, 7, 0, 0, 24'hFFFFFF, 0, 0);
    list.push_back(make_sample(11, 3, 255, 255, 255, 0, 0, 0, 0, 0));
    list.push_back(make_sample(12, 3, 0, 0, 0, 65535, 0, 0, 0, 0));
    send_list(list);
    list.delete();
    configure(511, 300, 7, 0, 0, 0, 0, 0);
    list.push_back(make_sample(13, 0, 100, 200, 255, 0, 0, 0, 0, 0));
    send_list(list);
  endtask

  // zero height, then zero channels: nothing is kept
  task automatic test_empty_image();
    icna_pkg::in_item_t list[$];
    configure(0, 16, 4, 0, 0, 65536, 0, 0);
    list.push_back(make_sample(20, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    send_list(list);
    list.delete();
    configure(16, 16, 0, 0, 0, 65536, 0, 0);
    list.push_back(make_sample(21, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    send_list(list);
  endtask

  // rotation of a full image that is not square
  task automatic test_nonsquare_rotation();
    icna_pkg::in_item_t list[$];
    configure(16, 40, 4, 0, 0, 65536, 2, 0);
    list.push_back(make_sample(30, 2, 15, 39, 33, 44, 0, 0, 0, 1));
    list.push_back(make_sample(31, 3, 0, 0, 55, 66, 0, 0, 0, 2));
    list.push_back(make_sample(32, 0, 3, 7, 77, 88, 0, 0, 0, 3));
    send_list(list);
  endtask

  function automatic int random_dim();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 256;
      2:       return $urandom_range(257, 511);
      default: return $urandom_range(2, 256);
    endcase
  endfunction

  task automatic random_config();
    int h, w, side, crop, win, scale;
    h = random_dim();
    w = random_dim();
    side = (dim_clamp(h) < dim_clamp(w)) ? dim_clamp(h) : dim_clamp(w);
    crop = 0;
    win = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6: crop = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 511)
                                                  : $urandom_range(1, side);
      7, 8: win = $urandom_range(1, 256);
      default: begin
        crop = $urandom_range(1, 256);
        win  = $urandom_range(1, 256);
      end
    endcase
    case ($urandom_range(0, 7))
      0:       scale = 0;
      1:       scale = 24'hFFFFFF;
      2:       scale = 65536;
      3:       scale = $urandom_range(0, 24'hFFFFFF);
      default: scale = $urandom_range(1, 1 << 18);
    endcase
    configure(h, w, $urandom_range(1, 7), crop, win, scale, $urandom_range(0, 3),
              $urandom_range(0, 1));
  endtask

  // mostly samples that land inside the window, the rest anywhere
  task automatic random_sample(output icna_pkg::in_item_t px);
    int oh, ow, hoff, woff, ih, iw, nch, hi, slack;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    px = noise[$bits(icna_pkg::in_item_t)-1:0];
    if ($urandom_range(0, 99) < 85) begin
      // draws mostly keep the crop inside the image
      slack = dim_clamp(int'(shadow.image_height)) - dim_clamp(int'(shadow.crop_side));
      px.row_offset_draw =
        8'($urandom_range(0, (slack > 0) ? ((slack > 255) ? 255 : slack) : 0));
      slack = dim_clamp(int'(shadow.image_width)) - dim_clamp(int'(shadow.crop_side));
      px.col_offset_draw =
        8'($urandom_range(0, (slack > 0) ? ((slack > 255) ? 255 : slack) : 0));
      void'(window_geometry(px.row_offset_draw, px.col_offset_draw, oh, ow, hoff, woff,
                            ih, iw));
      nch = (shadow.channel_count > icna_pkg::MAX_CHANNELS) ? icna_pkg::MAX_CHANNELS
                                                            : int'(shadow.channel_count);
      if (nch > 0) px.channel = 2'($urandom_range(0, nch - 1));
      hi = ((hoff + oh < ih) ? hoff + oh : ih) - 1;
      if (hi >= hoff) px.src_row = 8'($urandom_range(hoff, hi));
      hi = ((woff + ow < iw) ? woff + ow : iw) - 1;
      if (hi >= woff) px.src_col = 8'($urandom_range(woff, hi));
      // mean close to the sample now and then, for small results
      if ($urandom_range(0, 3) == 0) px.mean_value = {px.pixel, 8'($urandom)};
    end
  endtask

  // several random settings under one idling pattern
  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    icna_pkg::in_item_t px;
    bit       kept;
    int       results, sent;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (5) begin
      random_config();
      results = 0;
      sent = 0;
      while (results < 47 && sent < 220) begin
        random_sample(px);
        send_sample(px, kept);
        sent++;
        if (kept) results++;
      end
    end
  endtask

  initial begin
    shadow = '{image_height: 9'd256, image_width: 9'd256, channel_count: 3'd3,
               crop_side: 9'd0, win_side: 9'd0, scale_factor: 24'd65536,
               augment_enable: 2'd0, training_mode: 1'b0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling on either side
    test_reset_values();
    test_crop_window_clash();
    test_training_crop_augment();
    test_window_exceeds_image();
    test_oversized_registers();
    test_empty_image();
    test_nonsquare_rotation();

    // random part: free flow, idle sender, stalling receiver, then both
    test_random_phase(0, 0);
    test_random_phase(47, 0);
    test_random_phase(0, 47);
    test_random_phase(37, 37);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
